/* rtl/core/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/core/u8wc_pkg.sv */
// types, constants and character class functions for the utf-8 word counter
package u8wc_pkg;

  localparam int OUT_BITS   = 32;
  localparam int CP_BITS    = 21;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  typedef logic [CP_BITS-1:0] code_point_t;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_WORD,
    CLS_APOS,
    CLS_SEP
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic        vowel;
    logic        consonant;
    logic        last;
  } char_event_t;

  function automatic logic is_ascii_letter(input code_point_t cp);
    return (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A);
  endfunction

  function automatic logic is_vowel(input code_point_t cp);
    code_point_t lo;
    logic        v;
    lo = cp | 21'h20;
    unique case (cp)
      21'hE1, 21'hE0, 21'hE3, 21'hE2, 21'hC1, 21'hC0, 21'hC3, 21'hC2,
      21'hE9, 21'hE8, 21'hEA, 21'hC9, 21'hC8, 21'hCA,
      21'hED, 21'hEC, 21'hCD, 21'hCC,
      21'hF3, 21'hF2, 21'hF5, 21'hF4, 21'hD3, 21'hD2, 21'hD5, 21'hD4,
      21'hFA, 21'hF9, 21'hDA, 21'hD9: v = 1'b1;
      default: v = 1'b0;
    endcase
    if (is_ascii_letter(cp) && (lo == 21'h61 || lo == 21'h65 || lo == 21'h69 ||
                                lo == 21'h6F || lo == 21'h75)) begin
      v = 1'b1;
    end
    return v;
  endfunction

  function automatic logic is_consonant(input code_point_t cp);
    if (is_ascii_letter(cp)) begin
      return !is_vowel(cp);
    end
    return cp == 21'hE7 || cp == 21'hC7;
  endfunction

  function automatic char_class_t classify(input code_point_t cp);
    char_class_t c;
    unique case (cp)
      21'h27, 21'h2018, 21'h2019: c = CLS_APOS;
      21'h2D, 21'h22, 21'h20, 21'h09, 21'h0A, 21'h0D,
      21'h2E, 21'h3F, 21'h3B, 21'h3A, 21'h2C, 21'h21,
      21'h5B, 21'h5D, 21'h28, 21'h29,
      21'h2013, 21'h2026, 21'h201C, 21'h201D: c = CLS_SEP;
      default: c = CLS_OTHER;
    endcase
    if (is_ascii_letter(cp) || (cp >= 21'h30 && cp <= 21'h39) || cp == 21'h5F ||
        is_vowel(cp) || cp == 21'hE7 || cp == 21'hC7) begin
      c = CLS_WORD;
    end
    return c;
  endfunction

endpackage

/* rtl/core/utf8_word_class_counter.sv */
// top level of the utf-8 word class counter
// Takes one byte of UTF-8 text per cycle and counts words, words that start
// with a vowel and words closed by a separator right after a consonant
// letter; the byte flagged end_of_text yields one result transfer with the
// three counts (clipped to 32 bits) and clears all counting state. The
// sustained rate is one byte per cycle: a byte is decoded and classified in
// the cycle it is taken and written into a 4-entry queue; the counters take
// it from the head of the queue, and the result register offers the result
// once the last byte is counted. The queue and the result
// register let input keep flowing while a result waits; input stalls only
// once the queue is full.
module utf8_word_class_counter import u8wc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_BITS-1:0] word_total,
  output logic [OUT_BITS-1:0] vowel_start_words,
  output logic [OUT_BITS-1:0] consonant_end_words
);

  logic        q_full;
  logic        push;
  char_event_t push_event;
  logic        q_not_empty;
  logic        pop;
  char_event_t head;

  u8wc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .q_full     (q_full),
    .push       (push),
    .push_event (push_event)
  );

  u8wc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_event(push_event),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  u8wc_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .head_valid         (q_not_empty),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .word_total         (word_total),
    .vowel_start_words  (vowel_start_words),
    .consonant_end_words(consonant_end_words)
  );

endmodule

/* rtl/core/u8wc_front.sv */
// front end: takes bytes, assembles code points and classifies them
module u8wc_front import u8wc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic        q_full,
  output logic        push,
  output char_event_t push_event
);

  code_point_t partial;
  code_point_t partial_next;
  logic [1:0]  pending;
  logic [1:0]  pending_next;
  code_point_t cp;
  logic        done;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    partial_next = partial;
    pending_next = pending;
    cp           = code_point_t'(text_byte);
    done         = 1'b0;
    priority if (pending != 2'd0) begin
      partial_next = {partial[CP_BITS-7:0], text_byte[5:0]};
      pending_next = pending - 2'd1;
      cp           = partial_next;
      done         = (pending == 2'd1);
    end else if (!text_byte[7]) begin
      done = 1'b1;
    end else if (text_byte[7:5] == 3'b110) begin
      partial_next = code_point_t'(text_byte[4:0]);
      pending_next = 2'd1;
    end else if (text_byte[7:4] == 4'b1110) begin
      partial_next = code_point_t'(text_byte[3:0]);
      pending_next = 2'd2;
    end else if (text_byte[7:3] == 5'b11110) begin
      partial_next = code_point_t'(text_byte[2:0]);
      pending_next = 2'd3;
    end else begin
      // stray continuation or invalid lead: one character of class other
      done = 1'b0;
    end
  end

  always_comb begin
    push_event.cls       = done ? classify(cp) : CLS_OTHER;
    push_event.vowel     = is_vowel(cp);
    push_event.consonant = is_consonant(cp);
    push_event.last      = end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      pending <= 2'd0;
    end else if (push) begin
      if (end_of_text) begin
        partial <= '0;
        pending <= 2'd0;
      end else begin
        partial <= partial_next;
        pending <= pending_next;
      end
    end
  end

endmodule

/* rtl/core/u8wc_queue.sv */
// short queue of classified characters between front and back
module u8wc_queue import u8wc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  char_event_t push_event,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output char_event_t head
);

  char_event_t             mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr;
  logic [Q_PTR_BITS-1:0]   rd_ptr;
  logic [Q_PTR_BITS:0]     count;

  assign full      = (count == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/u8wc_back.sv */
// back end: word tracking, saturating counters and the result register
module u8wc_back import u8wc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  char_event_t         head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_BITS-1:0] word_total,
  output logic [OUT_BITS-1:0] vowel_start_words,
  output logic [OUT_BITS-1:0] consonant_end_words
);

  localparam int WIDE_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;

  logic   inside_word;
  logic   inside_word_next;
  logic   last_consonant;
  logic   last_consonant_next;
  count_t words;
  count_t words_next;
  count_t vowel_starts;
  count_t vowel_starts_next;
  count_t consonant_ends;
  count_t consonant_ends_next;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_BITS-1:0] clip(input count_t v);
    logic [WIDE_BITS-1:0] w;
    logic [OUT_BITS-1:0]  r;
    w = WIDE_BITS'(v);
    if (w > WIDE_BITS'({OUT_BITS{1'b1}})) begin
      r = '1;
    end else begin
      r = OUT_BITS'(w);
    end
    return r;
  endfunction

  assign pop = head_valid && (!head.last || !out_valid || !out_stall);

  always_comb begin
    inside_word_next    = inside_word;
    last_consonant_next = last_consonant;
    words_next          = words;
    vowel_starts_next   = vowel_starts;
    consonant_ends_next = consonant_ends;
    priority if (!inside_word) begin
      if (head.cls == CLS_WORD) begin
        inside_word_next    = 1'b1;
        last_consonant_next = head.consonant;
        words_next          = sat_inc(words);
        if (head.vowel) begin
          vowel_starts_next = sat_inc(vowel_starts);
        end
      end
    end else if (head.cls == CLS_WORD || head.cls == CLS_APOS) begin
      last_consonant_next = (head.cls == CLS_WORD) && head.consonant;
    end else if (head.cls == CLS_SEP) begin
      if (last_consonant) begin
        consonant_ends_next = sat_inc(consonant_ends);
      end
      inside_word_next = 1'b0;
    end else begin
      // other characters leave the word open
      inside_word_next = inside_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word    <= 1'b0;
      last_consonant <= 1'b0;
      words          <= '0;
      vowel_starts   <= '0;
      consonant_ends <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop && head.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          inside_word    <= 1'b0;
          last_consonant <= 1'b0;
          words          <= '0;
          vowel_starts   <= '0;
          consonant_ends <= '0;
        end else begin
          inside_word    <= inside_word_next;
          last_consonant <= last_consonant_next;
          words          <= words_next;
          vowel_starts   <= vowel_starts_next;
          consonant_ends <= consonant_ends_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      word_total          <= clip(words_next);
      vowel_start_words   <= clip(vowel_starts_next);
      consonant_end_words <= clip(consonant_ends_next);
    end
  end

endmodule

/* rtl/core/u8wc_checker.sv */
// port-level checks for the utf-8 word class counter, bound to the top level
`include "assert_macros.svh"

module u8wc_checker import u8wc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [OUT_BITS-1:0] word_total,
  input logic [OUT_BITS-1:0] vowel_start_words,
  input logic [OUT_BITS-1:0] consonant_end_words
);

  // a held result stays offered
  `ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a held result keeps its word total and consonant-end count
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall,
               $stable(word_total) && $stable(consonant_end_words),
               "result changed while stalled")

  // vowel-start words are a subset of all words
  `ASSERT_SAME(a_vowel_le_total, out_valid, vowel_start_words <= word_total,
               "more vowel-start words than words")

  // each word closes at most once
  `ASSERT_SAME(a_cons_le_total, out_valid, consonant_end_words <= word_total,
               "more consonant endings than words")

endmodule

bind utf8_word_class_counter u8wc_checker u_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .word_total         (word_total),
  .vowel_start_words  (vowel_start_words),
  .consonant_end_words(consonant_end_words)
);

/* tb/tb_top.sv */
// self-checking testbench for the utf-8 word class counter: directed and random text
module tb_top import u8wc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_BITS = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 260;

  localparam logic [20:0] VOWEL_ACC [30] = '{
    21'hE1, 21'hE0, 21'hE3, 21'hE2, 21'hC1, 21'hC0, 21'hC3, 21'hC2,
    21'hE9, 21'hE8, 21'hEA, 21'hC9, 21'hC8, 21'hCA,
    21'hED, 21'hEC, 21'hCD, 21'hCC,
    21'hF3, 21'hF2, 21'hF5, 21'hF4, 21'hD3, 21'hD2, 21'hD5, 21'hD4,
    21'hFA, 21'hF9, 21'hDA, 21'hD9
  };
  localparam logic [20:0] APOS_CPS [3] = '{21'h27, 21'h2018, 21'h2019};
  localparam logic [20:0] SEP_CPS [20] = '{
    21'h2D, 21'h22, 21'h20, 21'h09, 21'h0A, 21'h0D, 21'h2E, 21'h3F,
    21'h3B, 21'h3A, 21'h2C, 21'h21, 21'h5B, 21'h5D, 21'h28, 21'h29,
    21'h2013, 21'h2026, 21'h201C, 21'h201D
  };
  localparam logic [20:0] C_CEDILLA_LO = 21'hE7;
  localparam logic [20:0] C_CEDILLA_UP = 21'hC7;

  typedef struct {
    logic [OUT_BITS-1:0] words;
    logic [OUT_BITS-1:0] vowel_words;
    logic [OUT_BITS-1:0] cons_words;
  } tally_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          text_byte = 8'h00;
  logic                end_of_text = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OUT_BITS-1:0] word_total;
  logic [OUT_BITS-1:0] vowel_start_words;
  logic [OUT_BITS-1:0] consonant_end_words;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          fail_count = 0;
  int          bytes_sent = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  text_buf [$];
  tally_t      tally_q [$];

  logic                  in_word;
  logic                  last_cons;
  logic [20:0]           cp_partial;
  logic [1:0]            cp_pending;
  logic [COUNT_BITS-1:0] word_cnt;
  logic [COUNT_BITS-1:0] vowel_cnt;
  logic [COUNT_BITS-1:0] cons_cnt;

  utf8_word_class_counter #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .word_total(word_total),
    .vowel_start_words(vowel_start_words),
    .consonant_end_words(consonant_end_words)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // prediction of the counting state

  function automatic logic letter_cp(input logic [20:0] cp);
    return (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A);
  endfunction

  function automatic logic vowel_cp(input logic [20:0] cp);
    logic [7:0] lc;
    lc = cp[7:0] | 8'h20;
    if (letter_cp(cp)) begin
      return lc == "a" || lc == "e" || lc == "i" || lc == "o" || lc == "u";
    end
    foreach (VOWEL_ACC[k]) begin
      if (cp == VOWEL_ACC[k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic consonant_cp(input logic [20:0] cp);
    if (letter_cp(cp)) begin
      return !vowel_cp(cp);
    end
    return cp == C_CEDILLA_LO || cp == C_CEDILLA_UP;
  endfunction

  function automatic char_class_t class_of(input logic [20:0] cp);
    if (letter_cp(cp) || (cp >= 21'h30 && cp <= 21'h39) || cp == 21'h5F ||
        vowel_cp(cp) || cp == C_CEDILLA_LO || cp == C_CEDILLA_UP) begin
      return CLS_WORD;
    end
    foreach (APOS_CPS[k]) begin
      if (cp == APOS_CPS[k]) return CLS_APOS;
    end
    foreach (SEP_CPS[k]) begin
      if (cp == SEP_CPS[k]) return CLS_SEP;
    end
    return CLS_OTHER;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_up(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_BITS-1:0] clip(input logic [COUNT_BITS-1:0] v);
    if (COUNT_BITS > OUT_BITS && (v >> OUT_BITS) != 0) begin
      return '1;
    end
    return OUT_BITS'(v);
  endfunction

  function automatic void clear_counts();
    in_word = 1'b0;
    last_cons = 1'b0;
    cp_partial = '0;
    cp_pending = '0;
    word_cnt = '0;
    vowel_cnt = '0;
    cons_cnt = '0;
  endfunction

  function automatic void take_cp(input logic [20:0] cp, input logic ok);
    char_class_t cls;
    cls = ok ? class_of(cp) : CLS_OTHER;
    if (!in_word) begin
      if (cls == CLS_WORD) begin
        in_word = 1'b1;
        last_cons = consonant_cp(cp);
        word_cnt = sat_up(word_cnt);
        if (vowel_cp(cp)) vowel_cnt = sat_up(vowel_cnt);
      end
    end else if (cls == CLS_WORD || cls == CLS_APOS) begin
      last_cons = (cls == CLS_WORD) && consonant_cp(cp);
    end else if (cls == CLS_SEP) begin
      if (last_cons) cons_cnt = sat_up(cons_cnt);
      in_word = 1'b0;
    end
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic eot);
    tally_t t;
    if (cp_pending != 0) begin
      cp_partial = {cp_partial[14:0], b[5:0]};
      cp_pending = cp_pending - 1'b1;
      if (cp_pending == 0) take_cp(cp_partial, 1'b1);
    end else if (b < 8'h80) begin
      take_cp({13'd0, b}, b != 8'h00);
    end else if (b >= 8'hC0 && b < 8'hE0) begin
      cp_partial = {16'd0, b[4:0]};
      cp_pending = 2'd1;
    end else if (b >= 8'hE0 && b < 8'hF0) begin
      cp_partial = {17'd0, b[3:0]};
      cp_pending = 2'd2;
    end else if (b >= 8'hF0 && b < 8'hF8) begin
      cp_partial = {18'd0, b[2:0]};
      cp_pending = 2'd3;
    end else begin
      take_cp({13'd0, b}, 1'b0);
    end
    if (eot) begin
      t.words = clip(word_cnt);
      t.vowel_words = clip(vowel_cnt);
      t.cons_words = clip(cons_cnt);
      tally_q.push_back(t);
      clear_counts();
    end
  endfunction

  // result checking, sampled mid-cycle ahead of the transfer edge

  always @(negedge clk) begin
    tally_t t;
    if (!rst && out_valid && !out_stall) begin
      if (tally_q.size() == 0) begin
        $error("result transfer with no count pending");
        fail_count++;
      end else begin
        t = tally_q.pop_front();
        if (word_total !== t.words) begin
          $error("word_total expected %0d got %0d", t.words, word_total);
          fail_count++;
        end
        if (vowel_start_words !== t.vowel_words) begin
          $error("vowel_start_words expected %0d got %0d", t.vowel_words, vowel_start_words);
          fail_count++;
        end
        if (consonant_end_words !== t.cons_words) begin
          $error("consonant_end_words expected %0d got %0d", t.cons_words,
                 consonant_end_words);
          fail_count++;
        end
      end
    end
  end

  // stimulus

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    track_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) begin
      send_byte(text_buf[i], i == text_buf.size() - 1);
    end
    text_buf.delete();
  endtask

  function automatic void put_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      text_buf.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      text_buf.push_back({3'b110, cp[10:6]});
      text_buf.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      text_buf.push_back({4'b1110, cp[15:12]});
      text_buf.push_back({2'b10, cp[11:6]});
      text_buf.push_back({2'b10, cp[5:0]});
    end else begin
      text_buf.push_back({5'b11110, cp[20:18]});
      text_buf.push_back({2'b10, cp[17:12]});
      text_buf.push_back({2'b10, cp[11:6]});
      text_buf.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void add_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) begin
      put_cp($urandom_range(1) ? 21'($urandom_range(8'h61, 8'h7A)) :
                                 21'($urandom_range(8'h41, 8'h5A)));
    end else if (r < 45) begin
      put_cp($urandom_range(3) == 0 ? 21'h5F : 21'($urandom_range(8'h30, 8'h39)));
    end else if (r < 55) begin
      if ($urandom_range(4) == 0) begin
        put_cp($urandom_range(1) ? C_CEDILLA_LO : C_CEDILLA_UP);
      end else begin
        put_cp(VOWEL_ACC[$urandom_range(29)]);
      end
    end else if (r < 60) begin
      put_cp(APOS_CPS[$urandom_range(2)]);
    end else if (r < 80) begin
      put_cp(SEP_CPS[$urandom_range(19)]);
    end else if (r < 92) begin
      case ($urandom_range(3))
        0: put_cp(21'($urandom_range(8'h7F)));
        1: put_cp(21'($urandom_range(21'h80, 21'h7FF)));
        2: put_cp(21'($urandom_range(21'h800, 21'hFFFF)));
        default: put_cp(21'($urandom_range(21'h10000, 21'h1FFFFF)));
      endcase
    end else begin
      text_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic test_directed_text();
    text_buf = '{8'h41, 8'h62, 8'h2C,
                 8'hC3, 8'hA7,
                 8'hC3, 8'h27,
                 8'hE2, 8'h80, 8'h9C,
                 8'h00, 8'h80, 8'hFF, 8'hF8,
                 8'hF0, 8'h9F, 8'h98, 8'h80,
                 8'hC1, 8'hA1,
                 8'hE2, 8'h80, 8'h99,
                 8'h5F, 8'hE2};
    send_text();
    text_buf = '{8'h7A};
    send_text();
  endtask

  task automatic test_random_text(input int idle, input int stall, input int n_bytes);
    int start;
    int target;
    idle_pct = idle;
    stall_pct = stall;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      target = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      while (text_buf.size() < target) add_char();
      // occasionally cut a sequence short at the end of text
      if ($urandom_range(9) == 0) begin
        text_buf.push_back(8'($urandom_range(8'hC0, 8'hF7)));
      end
      send_text();
    end
  endtask

  initial begin
    clear_counts();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_text();
    test_random_text(0, 0, PHASE_BYTES);
    test_random_text(48, 0, PHASE_BYTES);
    test_random_text(0, 48, PHASE_BYTES);
    test_random_text(34, 34, PHASE_BYTES);
    in_valid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
